### rtl/core/v3fu_pkg.sv
// ----------------------------------------------------------------------------
// v3fu_pkg
// Shared types and constants for the three-component fixed-point vector unit.
// ----------------------------------------------------------------------------
package v3fu_pkg;

  typedef enum logic [2:0] {
    ACT_ADD       = 3'd0,
    ACT_SUB       = 3'd1,
    ACT_SCALE     = 3'd2,
    ACT_DOT       = 3'd3,
    ACT_CROSS     = 3'd4,
    ACT_LENGTH    = 3'd5,
    ACT_LENGTH_SQ = 3'd6,
    ACT_NORMALIZE = 3'd7
  } action_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] factor;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_scalar;
    logic               tiny_flag;
    logic               saturated;
  } result_t;

  // Square root resolves one result bit per stage.
  localparam int SQRT_STAGES = 32;

  // Width of the unclamped intermediate results.
  localparam int WIDE_W = 66;

  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_TINY_THRESHOLD = 3'd0;
  localparam logic [31:0] TINY_THRESHOLD_RESET = 32'd43;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = -66'sd2147483648;

  // Partial result carried alongside the square root and divider stages.
  typedef struct packed {
    action_t            action;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_scalar;
    logic               tiny;
    logic               sat;
    logic [31:0]        mag_x;
    logic [31:0]        mag_y;
    logic [31:0]        mag_z;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
  } side_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               hit;
  } clamp_t;

  function automatic clamp_t clamp32(input logic signed [WIDE_W-1:0] v);
    clamp_t r;
    if (v > WIDE_MAX) begin
      r.value = 32'sh7fffffff;
      r.hit   = 1'b1;
    end else if (v < WIDE_MIN) begin
      r.value = $signed(32'h80000000);
      r.hit   = 1'b1;
    end else begin
      r.value = $signed(v[31:0]);
      r.hit   = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/core/v3fu_sqrt.sv
// ----------------------------------------------------------------------------
// v3fu_sqrt
// Pipelined floor square root of a 64-bit radicand, one result bit a stage.
// ----------------------------------------------------------------------------
module v3fu_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  localparam int N = v3fu_pkg::SQRT_STAGES;

  logic [63:0] rem [N];
  logic [63:0] acc [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (2 * (N - 1 - i));
    logic [63:0] rem_in;
    logic [63:0] acc_in;
    logic [64:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign rem_in = radicand;
      assign acc_in = '0;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign acc_in = acc[i-1];
    end

    assign trial = {1'b0, acc_in} + {1'b0, BIT};
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= take ? rem_in - trial[63:0] : rem_in;
        acc[i] <= take ? (acc_in >> 1) + BIT : acc_in >> 1;
      end
    end
  end

  assign root = acc[N-1][31:0];

endmodule

### rtl/core/v3fu_div.sv
// ----------------------------------------------------------------------------
// v3fu_div
// Pipelined restoring divide of (dividend << FRAC_BITS) by divisor, for
// dividend no larger than divisor; one quotient bit a stage.
// ----------------------------------------------------------------------------
module v3fu_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        dividend,
  input  logic [31:0]        divisor,
  output logic [FRAC_BITS:0] quotient
);

  localparam int D = FRAC_BITS + 1;

  logic [31:0]  rem  [D];
  logic [31:0]  dvs  [D];
  logic [D-1:0] quo  [D];

  for (genvar j = 0; j < D; j++) begin : g_stage
    logic [32:0]  val;
    logic [32:0]  diff;
    logic [31:0]  d_in;
    logic [D-1:0] q_in;
    logic         take;

    if (j == 0) begin : g_first
      assign val  = {1'b0, dividend};
      assign d_in = divisor;
      assign q_in = '0;
    end else begin : g_next
      assign val  = {rem[j-1], 1'b0};
      assign d_in = dvs[j-1];
      assign q_in = quo[j-1];
    end

    assign diff = val - {1'b0, d_in};
    assign take = val >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= take ? diff[31:0] : val[31:0];
        dvs[j] <= d_in;
        quo[j] <= {q_in[D-2:0], take};
      end
    end
  end

  assign quotient = quo[D-1];

endmodule

### rtl/core/vec3_fixed_point_vector_unit.sv
// ----------------------------------------------------------------------------
// vec3_fixed_point_vector_unit
// Fixed-point three-component vector ALU with saturating results.
// ----------------------------------------------------------------------------
// The unit takes one item per cycle while the input side is not stalled, and
// returns one result per item, in order.
// Every item walks the full pipeline: operand select, multiply, sum, clamp,
// a 32-stage square root and a (FRAC_BITS+1)-stage divider, then a two-entry
// output queue. The latency is set by the square root and divider depth.
// The input side stalls only when the output queue holds two results.
// tiny_threshold is read at the clamp stage; write it while the unit is idle.
module vec3_fixed_point_vector_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  v3fu_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output v3fu_pkg::result_t                   result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [v3fu_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int W    = v3fu_pkg::WIDE_W;
  localparam int SQ   = v3fu_pkg::SQRT_STAGES;
  localparam int LAST = SQ + FRAC_BITS + 1;

  // Configuration
  logic [31:0] tiny_threshold;

  assign pready = 1'b1;
  assign prdata = (paddr == v3fu_pkg::ADDR_TINY_THRESHOLD) ? tiny_threshold : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tiny_threshold <= v3fu_pkg::TINY_THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == v3fu_pkg::ADDR_TINY_THRESHOLD) begin
      tiny_threshold <= pwdata;
    end
  end

  // Pipeline control
  logic [1:0] q_count;
  logic       advance;

  assign advance    = (q_count != 2'd2);
  assign item_ready = advance;

  // Stage A: transfer register
  v3fu_pkg::item_t a_item;
  logic            a_v;

  // Stage M: products
  v3fu_pkg::item_t    m_item;
  logic               m_v;
  logic signed [63:0] m_p [6];
  logic signed [31:0] lhs [6];
  logic signed [31:0] rhs [6];

  always_comb begin
    lhs[3] = a_item.a_x;  rhs[3] = a_item.b_z;
    lhs[4] = a_item.a_x;  rhs[4] = a_item.b_y;
    lhs[5] = a_item.a_y;  rhs[5] = a_item.b_x;
    case (a_item.action)
      v3fu_pkg::ACT_SCALE: begin
        lhs[0] = a_item.a_x;  rhs[0] = a_item.factor;
        lhs[1] = a_item.a_y;  rhs[1] = a_item.factor;
        lhs[2] = a_item.a_z;  rhs[2] = a_item.factor;
      end
      v3fu_pkg::ACT_DOT: begin
        lhs[0] = a_item.a_x;  rhs[0] = a_item.b_x;
        lhs[1] = a_item.a_y;  rhs[1] = a_item.b_y;
        lhs[2] = a_item.a_z;  rhs[2] = a_item.b_z;
      end
      v3fu_pkg::ACT_CROSS: begin
        lhs[0] = a_item.a_y;  rhs[0] = a_item.b_z;
        lhs[1] = a_item.a_z;  rhs[1] = a_item.b_y;
        lhs[2] = a_item.a_z;  rhs[2] = a_item.b_x;
      end
      default: begin
        // squares for length, length squared and normalize
        lhs[0] = a_item.a_x;  rhs[0] = a_item.a_x;
        lhs[1] = a_item.a_y;  rhs[1] = a_item.a_y;
        lhs[2] = a_item.a_z;  rhs[2] = a_item.a_z;
      end
    endcase
  end

  // Stage C: shifted sums
  v3fu_pkg::item_t    c_item;
  logic               c_v;
  logic signed [W-1:0] c_vx, c_vy, c_vz, c_vs;
  logic [63:0]        c_s;

  logic signed [63:0]  sh [6];
  logic [63:0]         s_sum;
  logic signed [W-1:0] vx, vy, vz, vs;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sh[k] = m_p[k] >>> FRAC_BITS;
    end
    s_sum = $unsigned(m_p[0]) + $unsigned(m_p[1]) + $unsigned(m_p[2]);
    vx = '0;
    vy = '0;
    vz = '0;
    vs = '0;
    case (m_item.action)
      v3fu_pkg::ACT_ADD: begin
        vx = W'(m_item.a_x) + W'(m_item.b_x);
        vy = W'(m_item.a_y) + W'(m_item.b_y);
        vz = W'(m_item.a_z) + W'(m_item.b_z);
      end
      v3fu_pkg::ACT_SUB: begin
        vx = W'(m_item.a_x) - W'(m_item.b_x);
        vy = W'(m_item.a_y) - W'(m_item.b_y);
        vz = W'(m_item.a_z) - W'(m_item.b_z);
      end
      v3fu_pkg::ACT_SCALE: begin
        vx = W'(sh[0]);
        vy = W'(sh[1]);
        vz = W'(sh[2]);
      end
      v3fu_pkg::ACT_DOT: begin
        vs = W'(sh[0]) + W'(sh[1]) + W'(sh[2]);
      end
      v3fu_pkg::ACT_CROSS: begin
        vx = W'(sh[0]) - W'(sh[1]);
        vy = W'(sh[2]) - W'(sh[3]);
        vz = W'(sh[4]) - W'(sh[5]);
      end
      v3fu_pkg::ACT_LENGTH_SQ: begin
        vs = $signed({2'b00, s_sum >> FRAC_BITS});
      end
      default: begin
        vs = '0;
      end
    endcase
  end

  // Stage D: clamp, then the side line
  v3fu_pkg::clamp_t cl_x, cl_y, cl_z, cl_s;
  v3fu_pkg::side_t  d_side;
  logic [63:0]      d_s;

  always_comb begin
    cl_x = v3fu_pkg::clamp32(c_vx);
    cl_y = v3fu_pkg::clamp32(c_vy);
    cl_z = v3fu_pkg::clamp32(c_vz);
    cl_s = v3fu_pkg::clamp32(c_vs);
    d_side.action     = c_item.action;
    d_side.out_x      = cl_x.value;
    d_side.out_y      = cl_y.value;
    d_side.out_z      = cl_z.value;
    d_side.out_scalar = cl_s.value;
    d_side.sat        = cl_x.hit | cl_y.hit | cl_z.hit | cl_s.hit;
    d_side.tiny       = (c_item.action == v3fu_pkg::ACT_NORMALIZE) &&
                        ((c_s < {32'd0, tiny_threshold}) || (c_s == 64'd0));
    d_side.neg_x      = c_item.a_x[31];
    d_side.neg_y      = c_item.a_y[31];
    d_side.neg_z      = c_item.a_z[31];
    d_side.mag_x      = c_item.a_x[31] ? ~c_item.a_x + 32'd1 : c_item.a_x;
    d_side.mag_y      = c_item.a_y[31] ? ~c_item.a_y + 32'd1 : c_item.a_y;
    d_side.mag_z      = c_item.a_z[31] ? ~c_item.a_z + 32'd1 : c_item.a_z;
  end

  v3fu_pkg::side_t sl [LAST+1];
  logic            vl [LAST+1];
  v3fu_pkg::side_t sl_len;
  logic [31:0]     root;

  // Length lands where the root leaves the square root stages.
  always_comb begin
    sl_len = sl[SQ];
    if (sl[SQ].action == v3fu_pkg::ACT_LENGTH) begin
      sl_len.out_scalar = root[31] ? 32'sh7fffffff : $signed(root);
      sl_len.sat        = root[31];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_item <= item;
      m_item <= a_item;
      for (int k = 0; k < 6; k++) begin
        m_p[k] <= 64'(lhs[k]) * 64'(rhs[k]);
      end
      c_item <= m_item;
      c_vx   <= vx;
      c_vy   <= vy;
      c_vz   <= vz;
      c_vs   <= vs;
      c_s    <= s_sum;
      d_s    <= c_s;
      sl[0]  <= d_side;
      for (int k = 1; k <= LAST; k++) begin
        sl[k] <= (k == SQ + 1) ? sl_len : sl[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      m_v <= 1'b0;
      c_v <= 1'b0;
      for (int k = 0; k <= LAST; k++) begin
        vl[k] <= 1'b0;
      end
    end else if (advance) begin
      a_v   <= item_valid;
      m_v   <= a_v;
      c_v   <= m_v;
      vl[0] <= c_v;
      for (int k = 1; k <= LAST; k++) begin
        vl[k] <= vl[k-1];
      end
    end
  end

  v3fu_sqrt u_sqrt (
    .clk      (clk),
    .en       (advance),
    .radicand (d_s),
    .root     (root)
  );

  logic [FRAC_BITS:0] q_x, q_y, q_z;

  v3fu_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk (clk), .en (advance), .dividend (sl[SQ].mag_x), .divisor (root), .quotient (q_x)
  );
  v3fu_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk (clk), .en (advance), .dividend (sl[SQ].mag_y), .divisor (root), .quotient (q_y)
  );
  v3fu_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk (clk), .en (advance), .dividend (sl[SQ].mag_z), .divisor (root), .quotient (q_z)
  );

  // Final assembly; the quotient never exceeds one, so no clamp is needed.
  v3fu_pkg::result_t res_new;
  logic [31:0]       qx_w, qy_w, qz_w;

  always_comb begin
    qx_w = 32'(q_x);
    qy_w = 32'(q_y);
    qz_w = 32'(q_z);
    res_new.out_x      = sl[LAST].out_x;
    res_new.out_y      = sl[LAST].out_y;
    res_new.out_z      = sl[LAST].out_z;
    res_new.out_scalar = sl[LAST].out_scalar;
    res_new.tiny_flag  = sl[LAST].tiny;
    res_new.saturated  = sl[LAST].sat;
    if (sl[LAST].action == v3fu_pkg::ACT_NORMALIZE && !sl[LAST].tiny) begin
      res_new.out_x = $signed(sl[LAST].neg_x ? 32'd0 - qx_w : qx_w);
      res_new.out_y = $signed(sl[LAST].neg_y ? 32'd0 - qy_w : qy_w);
      res_new.out_z = $signed(sl[LAST].neg_z ? 32'd0 - qz_w : qz_w);
    end
  end

  // Output queue, two entries, head in q_head
  v3fu_pkg::result_t q_head, q_tail;
  logic              push, pop;

  assign push         = advance && vl[LAST];
  assign pop          = result_valid && result_ready;
  assign result_valid = (q_count != 2'd0);
  assign result       = q_head;

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (q_count == 2'd0) begin
        q_head <= res_new;
      end else begin
        q_tail <= res_new;
      end
    end else if (pop && !push) begin
      q_head <= q_tail;
    end else if (push && pop) begin
      q_head <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else if (push && !pop) begin
      q_count <= q_count + 2'd1;
    end else if (pop && !push) begin
      q_count <= q_count - 2'd1;
    end
  end

endmodule

### test/tb_vec3_fixed_point_vector_unit.sv
// ----------------------------------------------------------------------------
// tb_vec3_fixed_point_vector_unit
// Drives directed and random vector items through the unit, predicts every
// result from the operands and the threshold register, and checks each
// transfer field by field in order under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_vec3_fixed_point_vector_unit;

  localparam int FB = 16;
  localparam int LATENCY = FB + 38;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  v3fu_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  v3fu_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [v3fu_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  v3fu_pkg::item_t pending_items[$];
  v3fu_pkg::result_t expected_results[$];
  logic [31:0] threshold;
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;

  vec3_fixed_point_vector_unit #(.FRAC_BITS(FB)) u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [65:0] fmul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [65:0] p;
    p = 66'(x) * 66'(y);
    return p >>> FB;
  endfunction

  function automatic logic [31:0] clamp_s(input logic signed [65:0] v, inout logic sat);
    if (v > 66'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -66'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [31:0] c);
    logic [63:0] m;
    m = c < 0 ? 64'(-65'(c)) : 64'(c);
    return m;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [65:0] unit_comp(input logic signed [31:0] c,
                                                   input logic [63:0] len);
    logic [63:0] q;
    q = (mag(c) << FB) / len;
    return c < 0 ? -66'(q) : 66'(q);
  endfunction

  function automatic v3fu_pkg::result_t predict_result(input v3fu_pkg::item_t it);
    v3fu_pkg::result_t r;
    logic sat;
    logic [63:0] sumsq, len;
    r = '0;
    sat = 1'b0;
    sumsq = mag(it.a_x) * mag(it.a_x) + mag(it.a_y) * mag(it.a_y)
          + mag(it.a_z) * mag(it.a_z);
    case (it.action)
      v3fu_pkg::ACT_ADD: begin
        r.out_x = clamp_s(66'(it.a_x) + 66'(it.b_x), sat);
        r.out_y = clamp_s(66'(it.a_y) + 66'(it.b_y), sat);
        r.out_z = clamp_s(66'(it.a_z) + 66'(it.b_z), sat);
      end
      v3fu_pkg::ACT_SUB: begin
        r.out_x = clamp_s(66'(it.a_x) - 66'(it.b_x), sat);
        r.out_y = clamp_s(66'(it.a_y) - 66'(it.b_y), sat);
        r.out_z = clamp_s(66'(it.a_z) - 66'(it.b_z), sat);
      end
      v3fu_pkg::ACT_SCALE: begin
        r.out_x = clamp_s(fmul(it.a_x, it.factor), sat);
        r.out_y = clamp_s(fmul(it.a_y, it.factor), sat);
        r.out_z = clamp_s(fmul(it.a_z, it.factor), sat);
      end
      v3fu_pkg::ACT_DOT: begin
        r.out_scalar = clamp_s(fmul(it.a_x, it.b_x) + fmul(it.a_y, it.b_y)
                               + fmul(it.a_z, it.b_z), sat);
      end
      v3fu_pkg::ACT_CROSS: begin
        r.out_x = clamp_s(fmul(it.a_y, it.b_z) - fmul(it.a_z, it.b_y), sat);
        r.out_y = clamp_s(fmul(it.a_z, it.b_x) - fmul(it.a_x, it.b_z), sat);
        r.out_z = clamp_s(fmul(it.a_x, it.b_y) - fmul(it.a_y, it.b_x), sat);
      end
      v3fu_pkg::ACT_LENGTH: begin
        r.out_scalar = clamp_s(66'(floor_sqrt(sumsq)), sat);
      end
      v3fu_pkg::ACT_LENGTH_SQ: begin
        r.out_scalar = clamp_s(66'(sumsq >> FB), sat);
      end
      default: begin
        len = floor_sqrt(sumsq);
        if (sumsq < 64'(threshold) || len == 0) begin
          r.tiny_flag = 1'b1;
        end else begin
          r.out_x = clamp_s(unit_comp(it.a_x, len), sat);
          r.out_y = clamp_s(unit_comp(it.a_y, len), sat);
          r.out_z = clamp_s(unit_comp(it.a_z, len), sat);
        end
      end
    endcase
    r.saturated = sat;
    return r;
  endfunction

  // Send items from the queue; predict at the transfer.
  always @(posedge clk) begin : drive
    int gap;
    if (!rst) begin
      if (item_valid && item_ready) begin
        expected_results.push_back(predict_result(item));
        void'(pending_items.pop_front());
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap == 0 && pending_items.size() > 0) begin
          item <= pending_items[0];
        end else begin
          item_valid <= 1'b0;
          send_gap <= (gap == 0) ? 0 : gap - 1;
        end
      end else if (!item_valid && pending_items.size() > 0) begin
        if (send_gap == 0) begin
          item <= pending_items[0];
          item_valid <= 1'b1;
        end else begin
          send_gap <= send_gap - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result);
          errors++;
        end else begin
          v3fu_pkg::result_t e;
          e = expected_results.pop_front();
          if (e.out_x !== result.out_x)
            $display("%0t: out_x expected %h got %h", $time, e.out_x, result.out_x);
          if (e.out_y !== result.out_y)
            $display("%0t: out_y expected %h got %h", $time, e.out_y, result.out_y);
          if (e.out_z !== result.out_z)
            $display("%0t: out_z expected %h got %h", $time, e.out_z, result.out_z);
          if (e.out_scalar !== result.out_scalar)
            $display("%0t: out_scalar expected %h got %h", $time, e.out_scalar,
                     result.out_scalar);
          if (e.tiny_flag !== result.tiny_flag)
            $display("%0t: tiny_flag expected %b got %b", $time, e.tiny_flag,
                     result.tiny_flag);
          if (e.saturated !== result.saturated)
            $display("%0t: saturated expected %b got %b", $time, e.saturated,
                     result.saturated);
          if (e !== result) errors++;
        end
      end
      if (recv_gap == 0) begin
        result_ready <= 1'b1;
        if (result_valid) recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end else begin
        result_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end
    end
  end

  task automatic write_threshold(input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= v3fu_pkg::ADDR_TINY_THRESHOLD;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    threshold = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain;
    wait (pending_items.size() == 0 && !item_valid && expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return 32'($signed($urandom_range(0, 8)) - 4);
      2: return $urandom & 32'h0003ffff ^ ($urandom_range(0, 1) ? 32'hffffffff : 0);
      3: return $urandom & 32'h00ffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input v3fu_pkg::action_t act,
                          input logic [31:0] ax, ay, az, bx, by, bz, f);
    v3fu_pkg::item_t it;
    it.action = act;
    it.a_x = ax; it.a_y = ay; it.a_z = az;
    it.b_x = bx; it.b_y = by; it.b_z = bz;
    it.factor = f;
    pending_items.push_back(it);
  endtask

  task automatic random_items(input int n);
    repeat (n) add_item(v3fu_pkg::action_t'($urandom_range(0, 7)), rnd_comp(), rnd_comp(),
                        rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
  endtask

  localparam logic [31:0] MAXV = 32'h7fffffff;
  localparam logic [31:0] MINV = 32'h80000000;
  localparam logic [31:0] ONE = 32'h00010000;

  initial begin
    threshold = v3fu_pkg::TINY_THRESHOLD_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes, each action, tiny and zero-length normalize.
    add_item(v3fu_pkg::ACT_ADD, MAXV, MINV, ONE, ONE, MINV, 0, MAXV);
    add_item(v3fu_pkg::ACT_SUB, MINV, MAXV, ONE, ONE, ONE, 0, 0);
    add_item(v3fu_pkg::ACT_SCALE, MAXV, MINV, ONE, 0, 0, 0, MINV);
    add_item(v3fu_pkg::ACT_SCALE, ONE, -ONE, 3, MAXV, MAXV, MAXV, 32'hffffffff);
    add_item(v3fu_pkg::ACT_DOT, MAXV, MINV, MINV, MAXV, MINV, MINV, 0);
    add_item(v3fu_pkg::ACT_DOT, ONE, 2 * ONE, -ONE, ONE, ONE, ONE, 0);
    add_item(v3fu_pkg::ACT_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
    add_item(v3fu_pkg::ACT_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0);
    add_item(v3fu_pkg::ACT_LENGTH, MINV, MINV, MINV, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_LENGTH, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_LENGTH_SQ, MAXV, MINV, MAXV, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_LENGTH_SQ, ONE, ONE, ONE, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_NORMALIZE, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_NORMALIZE, 1, 1, 1, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_NORMALIZE, 6, 0, 0, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_NORMALIZE, 7, 0, 0, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_NORMALIZE, 0, 0, 0, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_NORMALIZE, MINV, 0, 0, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_NORMALIZE, 1, 0, 0, 0, 0, 0, 0);
    random_items(80);
    drain();
    write_threshold(32'd0);
    add_item(v3fu_pkg::ACT_NORMALIZE, 0, 0, 0, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_NORMALIZE, 1, 0, 0, 0, 0, 0, 0);
    random_items(100);
    drain();
    write_threshold(32'hffffffff);
    add_item(v3fu_pkg::ACT_NORMALIZE, ONE, 0, 0, 0, 0, 0, 0);
    add_item(v3fu_pkg::ACT_NORMALIZE, MAXV, 0, 0, 0, 0, 0, 0);
    random_items(100);
    drain();
    write_threshold($urandom);
    random_items(100);
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/v3fu_pkg.sv
rtl/core/v3fu_sqrt.sv
rtl/core/v3fu_div.sv
rtl/core/vec3_fixed_point_vector_unit.sv
test/tb_vec3_fixed_point_vector_unit.sv
